@@ hdl/calendar_time_from_elapsed_ms_defines.svh @@
// ----------------------------------------------------------------------------
// calendar_time_from_elapsed_ms_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef CALENDAR_TIME_FROM_ELAPSED_MS_DEFINES_SVH
`define CALENDAR_TIME_FROM_ELAPSED_MS_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define CTFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked assertion, also checked during reset
`define CTFE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/ctfe_pkg.sv @@
// ----------------------------------------------------------------------------
// ctfe_pkg
// widths, register indexes and pipeline constants of the calendar time block
// ----------------------------------------------------------------------------
`default_nettype none

package ctfe_pkg;

    localparam int ELAPSED_W  = 32;
    localparam int MS_W       = 10;
    localparam int SEC_W      = 6;
    localparam int MIN_W      = 6;
    localparam int HR_W       = 5;
    localparam int WD_W       = 3;
    localparam int DATE_W     = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_MS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECONDS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MINUTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOURS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEEKDAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DATE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MONTH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_YEAR    = 3'd7;

    localparam logic [DATE_W-1:0]  DATE_RST  = 5'd1;
    localparam logic [MONTH_W-1:0] MONTH_RST = 4'd1;

    function automatic int cdiv_q_w(input int in_w, input int odd, input int shift);
        return in_w - shift - $clog2(odd) + 1;
    endfunction

    function automatic int cdiv_r_w(input int odd, input int shift);
        return $clog2(odd) + shift;
    endfunction

    // 1000 = 125 * 8, 60 = 15 * 4, 24 = 3 * 8
    localparam int MS_ODD     = 125;
    localparam int MS_SHIFT   = 3;
    localparam int MS_SUM_W   = ELAPSED_W + 1;
    localparam int MS_Q_W     = cdiv_q_w(MS_SUM_W, MS_ODD, MS_SHIFT);

    localparam int SEC_ODD    = 15;
    localparam int SEC_SHIFT  = 2;
    localparam int SEC_SUM_W  = MS_Q_W + 1;
    localparam int SEC_Q_W    = cdiv_q_w(SEC_SUM_W, SEC_ODD, SEC_SHIFT);

    localparam int MIN_ODD    = 15;
    localparam int MIN_SHIFT  = 2;
    localparam int MIN_SUM_W  = SEC_Q_W + 1;
    localparam int MIN_Q_W    = cdiv_q_w(MIN_SUM_W, MIN_ODD, MIN_SHIFT);

    localparam int HR_ODD     = 3;
    localparam int HR_SHIFT   = 3;
    localparam int HR_SUM_W   = MIN_Q_W + 1;
    localparam int HR_Q_W     = cdiv_q_w(HR_SUM_W, HR_ODD, HR_SHIFT);

    // day carry never exceeds 51
    localparam int DAY_CARRY_W = 7;

    localparam int WD_ODD     = 7;
    localparam int WD_SHIFT   = 0;
    localparam int WD_SUM_W   = DAY_CARRY_W + 1;

    localparam int CDIV_LAT   = 3;
    localparam int DATE_LAT   = 3;
    localparam int PIPE_LAT   = 4 * CDIV_LAT + DATE_LAT;

    typedef struct packed {
        logic [MS_W-1:0]    ms;
        logic [SEC_W-1:0]   seconds;
        logic [MIN_W-1:0]   minutes;
        logic [HR_W-1:0]    hours;
        logic [WD_W-1:0]    weekday;
        logic [DATE_W-1:0]  date;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_cfg;

endpackage

`default_nettype wire

@@ hdl/calendar_time_from_elapsed_ms.sv @@
// ----------------------------------------------------------------------------
// calendar_time_from_elapsed_ms
// an accepted item reaches its o_strobe cycle through four chained
// three-stage constant dividers and three weekday and date stages
// throughput: one item per cycle, every stage is registered with no feedback
// busy is high only during reset and the cycle after; results cannot stall
// reset: start time 00:00:00.000, Sunday, day 1, month 1, year 00; no items
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_time_from_elapsed_ms
    import ctfe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [ELAPSED_W-1:0]  i_elapsed_ms,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_strobe,
    output logic      [MS_W-1:0]       o_now_ms,
    output logic      [SEC_W-1:0]      o_now_seconds,
    output logic      [MIN_W-1:0]      o_now_minutes,
    output logic      [HR_W-1:0]       o_now_hours,
    output logic      [WD_W-1:0]       o_now_weekday,
    output logic      [DATE_W-1:0]     o_now_date,
    output logic      [MONTH_W-1:0]    o_now_month,
    output logic      [YEAR_W-1:0]     o_now_year
);

    t_cfg                r_cfg;
    logic                r_busy;
    logic [PIPE_LAT-1:0] r_valid;
    logic                accept;

    logic [MS_Q_W-1:0]   ms_quot;
    logic [MS_W-1:0]     ms_rem;
    logic [SEC_Q_W-1:0]  sec_quot;
    logic [SEC_W-1:0]    sec_rem;
    logic [MIN_Q_W-1:0]  min_quot;
    logic [MIN_W-1:0]    min_rem;
    logic [HR_Q_W-1:0]   hr_quot;
    logic [HR_W-1:0]     hr_rem;

    assign accept      = start && !busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_valid[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{ms: '0, seconds: '0, minutes: '0, hours: '0, weekday: '0,
                       date: DATE_RST, month: MONTH_RST, year: '0};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_MS:      r_cfg.ms      <= i_cfg_data[MS_W-1:0];
                REG_SECONDS: r_cfg.seconds <= i_cfg_data[SEC_W-1:0];
                REG_MINUTES: r_cfg.minutes <= i_cfg_data[MIN_W-1:0];
                REG_HOURS:   r_cfg.hours   <= i_cfg_data[HR_W-1:0];
                REG_WEEKDAY: r_cfg.weekday <= i_cfg_data[WD_W-1:0];
                REG_DATE:    r_cfg.date    <= i_cfg_data[DATE_W-1:0];
                REG_MONTH:   r_cfg.month   <= i_cfg_data[MONTH_W-1:0];
                REG_YEAR:    r_cfg.year    <= i_cfg_data[YEAR_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_valid <= '0;
        end else begin
            r_busy  <= 1'b0;
            r_valid <= {r_valid[PIPE_LAT-2:0], accept};
        end
    end

    ctfe_cdiv #(.IN_W(MS_SUM_W), .ODD(MS_ODD), .SHIFT(MS_SHIFT)) u_div_ms (
        .i_clk  (i_clk),
        .i_a    (MS_SUM_W'(r_cfg.ms)),
        .i_b    (MS_SUM_W'(i_elapsed_ms)),
        .o_quot (ms_quot),
        .o_rem  (ms_rem)
    );

    ctfe_cdiv #(.IN_W(SEC_SUM_W), .ODD(SEC_ODD), .SHIFT(SEC_SHIFT)) u_div_sec (
        .i_clk  (i_clk),
        .i_a    (SEC_SUM_W'(r_cfg.seconds)),
        .i_b    (SEC_SUM_W'(ms_quot)),
        .o_quot (sec_quot),
        .o_rem  (sec_rem)
    );

    ctfe_cdiv #(.IN_W(MIN_SUM_W), .ODD(MIN_ODD), .SHIFT(MIN_SHIFT)) u_div_min (
        .i_clk  (i_clk),
        .i_a    (MIN_SUM_W'(r_cfg.minutes)),
        .i_b    (MIN_SUM_W'(sec_quot)),
        .o_quot (min_quot),
        .o_rem  (min_rem)
    );

    ctfe_cdiv #(.IN_W(HR_SUM_W), .ODD(HR_ODD), .SHIFT(HR_SHIFT)) u_div_hr (
        .i_clk  (i_clk),
        .i_a    (HR_SUM_W'(r_cfg.hours)),
        .i_b    (HR_SUM_W'(min_quot)),
        .o_quot (hr_quot),
        .o_rem  (hr_rem)
    );

    ctfe_cdiv #(.IN_W(WD_SUM_W), .ODD(WD_ODD), .SHIFT(WD_SHIFT)) u_div_wd (
        .i_clk  (i_clk),
        .i_a    (WD_SUM_W'(r_cfg.weekday)),
        .i_b    (WD_SUM_W'(hr_quot[DAY_CARRY_W-1:0])),
        .o_quot (),
        .o_rem  (o_now_weekday)
    );

    ctfe_date u_date (
        .i_clk   (i_clk),
        .i_cfg   (r_cfg),
        .i_carry (hr_quot[DAY_CARRY_W-1:0]),
        .o_date  (o_now_date),
        .o_month (o_now_month),
        .o_year  (o_now_year)
    );

    ctfe_delay #(.W(MS_W), .DEPTH(PIPE_LAT - CDIV_LAT)) u_dly_ms (
        .i_clk (i_clk),
        .i_d   (ms_rem),
        .o_q   (o_now_ms)
    );

    ctfe_delay #(.W(SEC_W), .DEPTH(PIPE_LAT - 2 * CDIV_LAT)) u_dly_sec (
        .i_clk (i_clk),
        .i_d   (sec_rem),
        .o_q   (o_now_seconds)
    );

    ctfe_delay #(.W(MIN_W), .DEPTH(PIPE_LAT - 3 * CDIV_LAT)) u_dly_min (
        .i_clk (i_clk),
        .i_d   (min_rem),
        .o_q   (o_now_minutes)
    );

    ctfe_delay #(.W(HR_W), .DEPTH(PIPE_LAT - 4 * CDIV_LAT)) u_dly_hr (
        .i_clk (i_clk),
        .i_d   (hr_rem),
        .o_q   (o_now_hours)
    );

endmodule

`default_nettype wire

@@ hdl/ctfe_cdiv.sv @@
// ----------------------------------------------------------------------------
// ctfe_cdiv
// three-stage add and divide by a constant: sum, reciprocal multiply, correct
// ----------------------------------------------------------------------------
`default_nettype none

module ctfe_cdiv
    import ctfe_pkg::*;
#(
    parameter int IN_W  = MS_SUM_W,
    parameter int ODD   = MS_ODD,
    parameter int SHIFT = MS_SHIFT
) (
    input  wire logic                               i_clk,
    input  wire logic [IN_W-1:0]                    i_a,
    input  wire logic [IN_W-1:0]                    i_b,
    output logic      [cdiv_q_w(IN_W, ODD, SHIFT)-1:0] o_quot,
    output logic      [cdiv_r_w(ODD, SHIFT)-1:0]       o_rem
);

    localparam int X_W  = IN_W - SHIFT;
    localparam int C_W  = $clog2(ODD);
    localparam int K    = X_W + C_W;
    localparam int M_W  = X_W + 1;
    localparam int P_W  = X_W + M_W;
    localparam int Q_W  = cdiv_q_w(IN_W, ODD, SHIFT);
    localparam int R_W  = cdiv_r_w(ODD, SHIFT);
    localparam int L_W  = (SHIFT > 0) ? SHIFT : 1;

    localparam logic [M_W-1:0] MULT    = M_W'((64'd1 << K) / 64'(ODD));
    localparam logic [X_W-1:0] ODD_X   = X_W'(ODD);
    localparam logic [C_W:0]   ODD_C   = (C_W + 1)'(ODD);
    localparam logic [L_W-1:0] LO_MASK = L_W'((1 << SHIFT) - 1);

    logic [IN_W-1:0] r_sum;
    logic [P_W-1:0]  r_prod;
    logic [X_W-1:0]  r_x;
    logic [L_W-1:0]  r_lo;
    logic [Q_W-1:0]  r_quot;
    logic [R_W-1:0]  r_rem;

    logic [X_W-1:0]  x;
    logic [Q_W-1:0]  q_est;
    logic [X_W-1:0]  diff;
    logic [C_W:0]    rem_raw;
    logic [C_W:0]    rem_fix;
    logic [Q_W-1:0]  n_quot;
    logic [R_W-1:0]  n_rem;

    assign x = X_W'(r_sum >> SHIFT);

    always_comb begin
        q_est   = r_prod[K +: Q_W];
        diff    = r_x - (X_W'(q_est) * ODD_X);
        rem_raw = diff[C_W:0];
        if (rem_raw >= ODD_C) begin
            rem_fix = rem_raw - ODD_C;
            n_quot  = q_est + Q_W'(1);
        end else begin
            rem_fix = rem_raw;
            n_quot  = q_est;
        end
        n_rem = R_W'(R_W'(rem_fix[C_W-1:0]) << SHIFT) | R_W'(r_lo);
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= i_a + i_b;
        r_prod <= P_W'(x) * P_W'(MULT);
        r_x    <= x;
        r_lo   <= L_W'(r_sum) & LO_MASK;
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

@@ hdl/ctfe_delay.sv @@
// ----------------------------------------------------------------------------
// ctfe_delay
// fixed-length register line that aligns a field with the pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module ctfe_delay
    import ctfe_pkg::*;
#(
    parameter int W     = MS_W,
    parameter int DEPTH = PIPE_LAT - CDIV_LAT
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_q
);

    logic [W-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        r_pipe[0] <= i_d;
        for (int i = 1; i < DEPTH; i++) begin
            r_pipe[i] <= r_pipe[i-1];
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

`default_nettype wire

@@ hdl/ctfe_date.sv @@
// ----------------------------------------------------------------------------
// ctfe_date
// day carry into day of month, month and two-digit year over three stages
// ----------------------------------------------------------------------------
`default_nettype none

module ctfe_date
    import ctfe_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire t_cfg                   i_cfg,
    input  wire logic [DAY_CARRY_W-1:0] i_carry,
    output logic      [DATE_W-1:0]      o_date,
    output logic      [MONTH_W-1:0]     o_month,
    output logic      [YEAR_W-1:0]      o_year
);

    localparam int DSUM_W = 8;
    localparam int MSUM_W = MONTH_W + 1;
    localparam int YSUM_W = YEAR_W + 1;

    localparam logic [DATE_W-1:0]  LEN_FEB      = 5'd28;
    localparam logic [DATE_W-1:0]  LEN_FEB_LEAP = 5'd29;
    localparam logic [DATE_W-1:0]  LEN_SHORT    = 5'd30;
    localparam logic [DATE_W-1:0]  LEN_LONG     = 5'd31;
    localparam logic [MONTH_W-1:0] MON_FEB      = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR      = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN      = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP      = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV      = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC      = 4'd12;
    localparam logic [MSUM_W-1:0]  MONTHS       = 5'd12;
    localparam logic [YSUM_W-1:0]  YEARS        = 8'd100;

    // stage 1
    logic [DSUM_W-1:0]  r_dsum;
    logic [DATE_W-1:0]  r_len;
    logic [MONTH_W-1:0] r_m0_a;
    logic [YEAR_W-1:0]  r_year_a;
    // stage 2
    logic [DATE_W-1:0]  r_date_b;
    logic [1:0]         r_dq;
    logic [MONTH_W-1:0] r_m0_b;
    logic [YEAR_W-1:0]  r_year_b;
    // stage 3
    logic [DATE_W-1:0]  r_date;
    logic [MONTH_W-1:0] r_month;
    logic [YEAR_W-1:0]  r_year;

    logic [DATE_W-1:0]  date_eff;
    logic [MONTH_W-1:0] month_eff;
    logic [DATE_W-1:0]  n_len;
    logic [DSUM_W-1:0]  n_dsum;
    logic [DSUM_W-1:0]  day_rem;
    logic [1:0]         n_dq;
    logic [MSUM_W-1:0]  msum;
    logic               ycarry;
    logic [YSUM_W-1:0]  ysum;

    // length follows the raw starting month
    always_comb begin
        unique case (i_cfg.month)
            MON_FEB: n_len = (i_cfg.year[1:0] == 2'd0) ? LEN_FEB_LEAP : LEN_FEB;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: n_len = LEN_SHORT;
            default: n_len = LEN_LONG;
        endcase
    end

    always_comb begin
        date_eff = (i_cfg.date == '0) ? DATE_W'(1) : i_cfg.date;
        priority if (i_cfg.month == '0) begin
            month_eff = MONTH_W'(1);
        end else if (i_cfg.month > MON_DEC) begin
            month_eff = MON_DEC;
        end else begin
            month_eff = i_cfg.month;
        end
        n_dsum = DSUM_W'(date_eff) - DSUM_W'(1) + DSUM_W'(i_carry);
    end

    // quotient is at most two
    always_comb begin
        day_rem = r_dsum;
        n_dq    = 2'd0;
        if (day_rem >= DSUM_W'(r_len)) begin
            day_rem = day_rem - DSUM_W'(r_len);
            n_dq    = 2'd1;
        end
        if (day_rem >= DSUM_W'(r_len)) begin
            day_rem = day_rem - DSUM_W'(r_len);
            n_dq    = 2'd2;
        end
    end

    always_comb begin
        msum   = MSUM_W'(r_m0_b) + MSUM_W'(r_dq);
        ycarry = 1'b0;
        if (msum >= MONTHS) begin
            msum   = msum - MONTHS;
            ycarry = 1'b1;
        end
        ysum = YSUM_W'(r_year_b) + YSUM_W'(ycarry);
        if (ysum >= YEARS) begin
            ysum = ysum - YEARS;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dsum   <= n_dsum;
        r_len    <= n_len;
        r_m0_a   <= month_eff - MONTH_W'(1);
        r_year_a <= i_cfg.year;

        r_date_b <= DATE_W'(day_rem) + DATE_W'(1);
        r_dq     <= n_dq;
        r_m0_b   <= r_m0_a;
        r_year_b <= r_year_a;

        r_date   <= r_date_b;
        r_month  <= MONTH_W'(msum) + MONTH_W'(1);
        r_year   <= YEAR_W'(ysum);
    end

    assign o_date  = r_date;
    assign o_month = r_month;
    assign o_year  = r_year;

endmodule

`default_nettype wire

@@ hdl/ctfe_checker.sv @@
// ----------------------------------------------------------------------------
// ctfe_checker
// port-level checks of item timing and result ranges, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "calendar_time_from_elapsed_ms_defines.svh"

module ctfe_checker
    import ctfe_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  o_strobe,
    input wire logic [MS_W-1:0]       o_now_ms,
    input wire logic [SEC_W-1:0]      o_now_seconds,
    input wire logic [MIN_W-1:0]      o_now_minutes,
    input wire logic [HR_W-1:0]       o_now_hours,
    input wire logic [WD_W-1:0]       o_now_weekday,
    input wire logic [DATE_W-1:0]     o_now_date,
    input wire logic [MONTH_W-1:0]    o_now_month,
    input wire logic [YEAR_W-1:0]     o_now_year
);

    logic accept;
    logic time_ok;
    logic date_ok;

    assign accept  = start && !busy;
    assign time_ok = (o_now_ms < 10'd1000) && (o_now_seconds < 6'd60) &&
                     (o_now_minutes < 6'd60) && (o_now_hours < 5'd24);
    assign date_ok = (o_now_weekday < 3'd7) && (o_now_date != 5'd0) &&
                     (o_now_month != 4'd0) && (o_now_month < 4'd13) &&
                     (o_now_year < 7'd100);

    `CTFE_ASSERT(a_item_gives_result, accept |-> ##PIPE_LAT o_strobe, "item lost")

    `CTFE_ASSERT(a_result_has_item, o_strobe |-> $past(accept, PIPE_LAT), "extra result")

    `CTFE_ASSERT(a_time_range, o_strobe |-> time_ok, "time of day out of range")

    `CTFE_ASSERT(a_date_range, o_strobe |-> date_ok, "date out of range")

    `CTFE_ASSERT_RST(a_reset_quiet, !i_rst_n |=> (!o_strobe && busy), "activity after reset")

endmodule

bind calendar_time_from_elapsed_ms ctfe_checker u_checker (.*);

`default_nettype wire
